FILE: design/framed_command_receiver_core_assert.svh
// Assertion macros shared by the receiver core
`ifndef FRAMED_COMMAND_RECEIVER_CORE_ASSERT_SVH
`define FRAMED_COMMAND_RECEIVER_CORE_ASSERT_SVH

// Check a same-cycle implication, masked while reset is asserted
`define FCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framed command receiver: assertion failed");

// Check an implication on the following cycle, never masked
`define FCR_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("framed command receiver: assertion failed");

`endif

FILE: design/fcr_pkg.sv
// Shared types and constants for the framed command receiver
`timescale 1ns / 1ps
`default_nettype none
package fcr_pkg;

    // Framing marks
    localparam logic [7:0] END_MARK = 8'h55;
    localparam logic [7:0] HDR_MARK = 8'hAA;

    // Default saturation point of the byte position counter
    localparam int POSITION_LIMIT_DEF = 511;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_HDR  = 3'd1;
    localparam logic [2:0] ST_BAD_CMD  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_BAD_CSUM = 3'd4;

    // One finished frame, as the front hands it to the back
    typedef struct packed {
        logic [6:0][7:0] front;
        logic [7:0]      rsum;
        logic [7:0]      csum;
    } t_frame;

    // Push request into the queue
    typedef struct packed {
        logic   valid;
        t_frame frame;
    } t_push;

endpackage
`default_nettype wire

FILE: design/fcr_front.sv
// Front end: tracks byte positions, sums the checksum and detects frame end
`timescale 1ns / 1ps
`default_nettype none
module fcr_front #(
    parameter int POSITION_LIMIT = fcr_pkg::POSITION_LIMIT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_full,
    output fcr_pkg::t_push     o_push
);
    import fcr_pkg::*;

    localparam int PW = $clog2(POSITION_LIMIT + 1);
    localparam int CW = (PW > 9) ? PW : 9;

    logic [PW-1:0]   r_pos,    n_pos;
    logic            r_armed,  n_armed;
    logic [6:0][7:0] r_front,  n_front;
    logic [7:0]      r_sum,    n_sum;
    logic [1:0][7:0] r_recent, n_recent;

    logic accept;
    logic in_range;
    logic counted;
    logic frame_end;

    // Take a request whenever the queue can absorb a finished frame
    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    assign in_range = r_pos < PW'(POSITION_LIMIT);
    assign counted  = (r_pos >= PW'(4)) &&
                      (CW'(r_pos) < (CW'(r_front[3]) + CW'(4)));
    assign frame_end = (i_rx_byte == END_MARK) && r_armed;

    // Next frame state for the accepted byte
    always_comb begin
        n_pos    = r_pos;
        n_armed  = r_armed;
        n_front  = r_front;
        n_sum    = r_sum;
        n_recent = r_recent;
        if (in_range) begin
            for (int k = 0; k < 7; k++) begin
                if (r_pos == PW'(k)) begin
                    n_front[k] = i_rx_byte;
                end
            end
            if (r_pos == PW'(2) || r_pos == PW'(3) || counted) begin
                n_sum = r_sum + i_rx_byte;
            end
            n_pos = r_pos + PW'(1);
        end
        n_recent[1] = r_recent[0];
        n_recent[0] = i_rx_byte;
        if (i_rx_byte == END_MARK) begin
            n_armed = 1'b1;
        end
    end

    // Hand the finished frame to the queue
    always_comb begin
        o_push.valid       = accept && frame_end;
        o_push.frame.front = n_front;
        o_push.frame.rsum  = r_recent[1];
        o_push.frame.csum  = n_sum;
    end

    // Hold frame state; clear it at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_armed  <= 1'b0;
            r_front  <= '0;
            r_sum    <= '0;
            r_recent <= '0;
        end else if (accept) begin
            if (frame_end) begin
                r_pos    <= '0;
                r_armed  <= 1'b0;
                r_front  <= '0;
                r_sum    <= '0;
                r_recent <= '0;
            end else begin
                r_pos    <= n_pos;
                r_armed  <= n_armed;
                r_front  <= n_front;
                r_sum    <= n_sum;
                r_recent <= n_recent;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/fcr_queue.sv
// Small queue of finished frames between front and back
`timescale 1ns / 1ps
`default_nettype none
module fcr_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire fcr_pkg::t_push i_push,
    output logic               o_full,
    output logic               o_head_valid,
    output fcr_pkg::t_frame    o_head,
    input  wire logic          i_pop
);
    import fcr_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    t_frame        r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_count,  n_count;

    logic do_push;
    logic do_pop;

    assign o_full       = r_count == NW'(QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head_valid;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + NW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - NW'(1);
        end
    end

    // Pointer and fill state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.frame;
        end
    end

endmodule
`default_nettype wire

FILE: design/fcr_back.sv
// Back end: checks the frame and holds the result for the output channel
`timescale 1ns / 1ps
`default_nettype none
module fcr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_head_valid,
    input  wire fcr_pkg::t_frame i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [2:0]         o_status,
    output logic [7:0]         o_hdr_first,
    output logic [7:0]         o_hdr_second,
    output logic [7:0]         o_command,
    output logic [7:0]         o_arg_count,
    output logic [7:0]         o_arg_first,
    output logic [7:0]         o_arg_second,
    output logic [7:0]         o_arg_third,
    output logic [7:0]         o_received_sum,
    output logic [7:0]         o_computed_sum
);
    import fcr_pkg::*;

    // Allowed counts per command, commands 1 to 5
    localparam logic [7:0] ALLOWED_COUNTS [5][2] = '{
        '{8'd1, 8'd2}, '{8'd1, 8'd3}, '{8'd1, 8'd2}, '{8'd2, 8'd0}, '{8'd1, 8'd0}
    };
    localparam logic [1:0] ALLOWED_NUM [5] = '{2'd2, 2'd2, 2'd2, 2'd1, 2'd1};

    logic       r_valid;
    logic [2:0] r_status;
    t_frame     r_frame;

    logic       load;
    logic       hdr_ok;
    logic       cmd_ok;
    logic       len_ok;
    logic [2:0] cmd_idx;
    logic [2:0] status;

    // Refill the output register when empty or being drained
    assign load  = i_head_valid && (!r_valid || i_ready);
    assign o_pop = load;

    assign hdr_ok  = (i_head.front[0] == HDR_MARK) && (i_head.front[1] == HDR_MARK);
    assign cmd_ok  = (i_head.front[2] >= 8'd1) && (i_head.front[2] <= 8'd5);
    assign cmd_idx = 3'(i_head.front[2] - 8'd1);

    // Look up the count against the allowed list of the command
    always_comb begin
        len_ok = 1'b0;
        if (cmd_ok) begin
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < ALLOWED_NUM[cmd_idx] &&
                    ALLOWED_COUNTS[cmd_idx][i] == i_head.front[3]) begin
                    len_ok = 1'b1;
                end
            end
        end
    end

    // Classify in priority order
    always_comb begin
        if (!hdr_ok) begin
            status = ST_BAD_HDR;
        end else if (!cmd_ok) begin
            status = ST_BAD_CMD;
        end else if (!len_ok) begin
            status = ST_BAD_LEN;
        end else if (i_head.csum != i_head.rsum) begin
            status = ST_BAD_CSUM;
        end else begin
            status = ST_OK;
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status <= status;
            r_frame  <= i_head;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_hdr_first    = r_frame.front[0];
    assign o_hdr_second   = r_frame.front[1];
    assign o_command      = r_frame.front[2];
    assign o_arg_count    = r_frame.front[3];
    assign o_arg_first    = r_frame.front[4];
    assign o_arg_second   = r_frame.front[5];
    assign o_arg_third    = r_frame.front[6];
    assign o_received_sum = r_frame.rsum;
    assign o_computed_sum = r_frame.csum;

endmodule
`default_nettype wire

FILE: design/framed_command_receiver_core.sv
// Throughput: one received byte per cycle, limited only by the two-entry frame queue.
// A frame result enters the queue at the edge that takes its terminator byte,
// then the output register once that register is empty or being drained.
// Reset: synchronous active-low i_rst_n clears the frame state, queue and output valid.
// The output register lets new bytes arrive while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
`include "framed_command_receiver_core_assert.svh"
module framed_command_receiver_core #(
    parameter int POSITION_LIMIT = fcr_pkg::POSITION_LIMIT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0]      o_status,
    output logic [7:0]      o_hdr_first,
    output logic [7:0]      o_hdr_second,
    output logic [7:0]      o_command,
    output logic [7:0]      o_arg_count,
    output logic [7:0]      o_arg_first,
    output logic [7:0]      o_arg_second,
    output logic [7:0]      o_arg_third,
    output logic [7:0]      o_received_sum,
    output logic [7:0]      o_computed_sum
);
    import fcr_pkg::*;

    t_push  push;
    logic   full;
    logic   head_valid;
    t_frame head;
    logic   pop;

    logic   hdr_good;
    logic   sums_match;
    logic   cmd_in_range;
    logic   past_cmd_check;

    // Accept bytes and build frames
    fcr_front #(
        .POSITION_LIMIT (POSITION_LIMIT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_push    (push)
    );

    // Decouple front and back
    fcr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // Check frames and drive the result channel
    fcr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (head_valid),
        .i_head         (head),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_hdr_first    (o_hdr_first),
        .o_hdr_second   (o_hdr_second),
        .o_command      (o_command),
        .o_arg_count    (o_arg_count),
        .o_arg_first    (o_arg_first),
        .o_arg_second   (o_arg_second),
        .o_arg_third    (o_arg_third),
        .o_received_sum (o_received_sum),
        .o_computed_sum (o_computed_sum)
    );

    // Checker terms on the result channel
    assign hdr_good       = (o_hdr_first == HDR_MARK) && (o_hdr_second == HDR_MARK);
    assign sums_match     = o_received_sum == o_computed_sum;
    assign cmd_in_range   = (o_command >= 8'd1) && (o_command <= 8'd5);
    assign past_cmd_check = (o_status == ST_OK) || (o_status == ST_BAD_LEN) ||
                            (o_status == ST_BAD_CSUM);

    // An accepted frame has a good header and matching checksums
    `FCR_ASSERT_NOW(a_ok_frame, i_clk, i_rst_n, o_valid && o_status == ST_OK, hdr_good && sums_match)
    // A bad header report really has a wrong header byte
    `FCR_ASSERT_NOW(a_bad_hdr, i_clk, i_rst_n, o_valid && o_status == ST_BAD_HDR, !hdr_good)
    // Past the command check the command number is in range
    `FCR_ASSERT_NOW(a_cmd_range, i_clk, i_rst_n, o_valid && past_cmd_check, cmd_in_range)
    // Reset drops any pending result
    `FCR_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_valid)

endmodule
`default_nettype wire

FILE: verif/framed_command_receiver_core_tb.sv
// Self-checking testbench for the framed command receiver core
`timescale 1ns / 1ps
module framed_command_receiver_core_tb;
    import fcr_pkg::*;

    localparam int CLK_PERIOD        = 4;
    localparam int RESET_CYCLES      = 5;
    localparam int TIMEOUT_CYCLES    = 250000;
    localparam int DRAIN_CYCLES      = 16;
    localparam int LONG_STALL_CYCLES = 300;
    localparam int MAX_DATA          = 6;
    localparam int BURST_FRAMES      = 12;

    // Valid command range and up to two allowed counts per command
    localparam logic [7:0] CMD_MIN = 8'd1;
    localparam logic [7:0] CMD_MAX = 8'd5;
    localparam logic [7:0] COUNT_ALLOW_A [5] = '{8'd1, 8'd1, 8'd1, 8'd2, 8'd1};
    localparam logic [7:0] COUNT_ALLOW_B [5] = '{8'd2, 8'd3, 8'd2, 8'd2, 8'd1};

    // Opening requests: minimal frame, accepted frame, bad header,
    // bad command with a mark as count, bad length with the terminator counted
    localparam logic [7:0] OPENING [25] = '{
        8'h55, 8'h55,
        8'hAA, 8'hAA, 8'h05, 8'h01, 8'hFF, 8'h05, 8'h55, 8'h55,
        8'h00, 8'hFF, 8'h55, 8'h55,
        8'hAA, 8'hAA, 8'h00, 8'h55, 8'h55,
        8'hAA, 8'hAA, 8'h01, 8'h03, 8'h55, 8'h55
    };

    typedef enum logic [1:0] {
        PHASE_RX_SLOW,
        PHASE_TX_SLOW,
        PHASE_FULL_RATE
    } traffic_phase_t;

    typedef struct {
        logic [7:0]     data;
        traffic_phase_t phase;
        logic           pause;
        logic           hold;
    } pending_byte_t;

    typedef struct {
        logic [2:0] status;
        logic [7:0] hdr_first;
        logic [7:0] hdr_second;
        logic [7:0] command;
        logic [7:0] arg_count;
        logic [7:0] arg_first;
        logic [7:0] arg_second;
        logic [7:0] arg_third;
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
    } frame_result_t;

    logic       i_clk     = 1'b0;
    logic       i_rst_n   = 1'b0;
    logic       i_valid   = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic       i_ready   = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_status;
    logic [7:0] o_hdr_first;
    logic [7:0] o_hdr_second;
    logic [7:0] o_command;
    logic [7:0] o_arg_count;
    logic [7:0] o_arg_first;
    logic [7:0] o_arg_second;
    logic [7:0] o_arg_third;
    logic [7:0] o_received_sum;
    logic [7:0] o_computed_sum;

    pending_byte_t  pending[$];
    frame_result_t  frames_due[$];
    int unsigned    mismatch_count = 0;
    int unsigned    bytes_taken    = 0;
    traffic_phase_t traffic_phase  = PHASE_RX_SLOW;
    logic           hold_start     = 1'b0;
    int unsigned    stall_left     = 0;

    // Frame tracking state of the predictor
    int unsigned frame_pos;
    logic        stop_armed;
    logic [7:0]  frame_head [7];
    logic [7:0]  sum_so_far;
    logic [7:0]  last_two [2];

    // Stimulus generation state
    traffic_phase_t gen_phase  = PHASE_RX_SLOW;
    logic           pause_next = 1'b0;
    logic           hold_next  = 1'b0;
    logic           marks_odd  = 1'b0;

    framed_command_receiver_core dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int sender_idle_pct(input traffic_phase_t ph);
        case (ph)
            PHASE_RX_SLOW: return 11;
            PHASE_TX_SLOW: return 52;
            default:       return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct(input traffic_phase_t ph);
        case (ph)
            PHASE_RX_SLOW: return 52;
            PHASE_TX_SLOW: return 11;
            default:       return 0;
        endcase
    endfunction

    function automatic logic count_allowed(input logic [7:0] cmd, input logic [7:0] cnt);
        int idx;
        if (cmd < CMD_MIN || cmd > CMD_MAX)
            return 1'b0;
        idx = int'(cmd - CMD_MIN);
        return (cnt == COUNT_ALLOW_A[idx]) || (cnt == COUNT_ALLOW_B[idx]);
    endfunction

    // Clear all per-frame tracking
    task automatic wipe_frame();
        frame_pos  = 0;
        stop_armed = 1'b0;
        sum_so_far = 8'd0;
        last_two[0] = 8'd0;
        last_two[1] = 8'd0;
        foreach (frame_head[k])
            frame_head[k] = 8'd0;
    endtask

    // Advance the frame state by one taken byte; queue a result at frame end
    task automatic track_rx_byte(input logic [7:0] b);
        frame_result_t res;
        logic [7:0]    sent_sum;
        if (frame_pos < POSITION_LIMIT_DEF) begin
            if (frame_pos < 7)
                frame_head[frame_pos] = b;
            if (frame_pos == 2 || frame_pos == 3)
                sum_so_far = sum_so_far + b;
            else if (frame_pos >= 4 && (frame_pos - 4) < frame_head[3])
                sum_so_far = sum_so_far + b;
            frame_pos++;
        end
        sent_sum    = last_two[1];
        last_two[1] = last_two[0];
        last_two[0] = b;
        if (b != END_MARK)
            return;
        if (!stop_armed) begin
            stop_armed = 1'b1;
            return;
        end
        if (frame_head[0] != HDR_MARK || frame_head[1] != HDR_MARK)
            res.status = ST_BAD_HDR;
        else if (frame_head[2] < CMD_MIN || frame_head[2] > CMD_MAX)
            res.status = ST_BAD_CMD;
        else if (!count_allowed(frame_head[2], frame_head[3]))
            res.status = ST_BAD_LEN;
        else if (sum_so_far != sent_sum)
            res.status = ST_BAD_CSUM;
        else
            res.status = ST_OK;
        res.hdr_first    = frame_head[0];
        res.hdr_second   = frame_head[1];
        res.command      = frame_head[2];
        res.arg_count    = frame_head[3];
        res.arg_first    = frame_head[4];
        res.arg_second   = frame_head[5];
        res.arg_third    = frame_head[6];
        res.received_sum = sent_sum;
        res.computed_sum = sum_so_far;
        frames_due.push_back(res);
        wipe_frame();
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare one delivered result with the oldest expected frame
    task automatic check_result();
        frame_result_t want;
        if (frames_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d command %02h",
                     $time, o_status, o_command);
            mismatch_count++;
            return;
        end
        want = frames_due.pop_front();
        check_field("status", {5'd0, want.status}, {5'd0, o_status});
        check_field("hdr_first", want.hdr_first, o_hdr_first);
        check_field("hdr_second", want.hdr_second, o_hdr_second);
        check_field("command", want.command, o_command);
        check_field("arg_count", want.arg_count, o_arg_count);
        check_field("arg_first", want.arg_first, o_arg_first);
        check_field("arg_second", want.arg_second, o_arg_second);
        check_field("arg_third", want.arg_third, o_arg_third);
        check_field("received_sum", want.received_sum, o_received_sum);
        check_field("computed_sum", want.computed_sum, o_computed_sum);
    endtask

    // Any byte except the end mark
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == END_MARK);
        return b;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        pending_byte_t item;
        item.data  = b;
        item.phase = gen_phase;
        item.pause = pause_next;
        item.hold  = hold_next;
        pause_next = 1'b0;
        hold_next  = 1'b0;
        if (b == END_MARK)
            marks_odd = !marks_odd;
        pending.push_back(item);
    endtask

    // Close any half-open frame so the next one starts at position zero
    task automatic resync();
        if (marks_odd)
            queue_byte(END_MARK);
    endtask

    // One frame: mostly well formed, some with a single defect, truncated or noise
    task automatic queue_frame();
        logic [7:0] body[$];
        logic [7:0] h0, h1, cmd, cnt, csum, sent;
        int         kind, ndata, cut;
        kind = $urandom_range(99);
        if (kind >= 96) begin
            repeat ($urandom_range(12, 1))
                queue_byte(8'($urandom_range(255)));
            return;
        end
        resync();
        h0  = HDR_MARK;
        h1  = HDR_MARK;
        cmd = 8'($urandom_range(CMD_MAX, CMD_MIN));
        cnt = $urandom_range(1) ? COUNT_ALLOW_A[cmd - CMD_MIN] : COUNT_ALLOW_B[cmd - CMD_MIN];
        if (kind >= 65 && kind < 72) begin
            do
                h0 = plain_byte();
            while (h0 == HDR_MARK);
            if ($urandom_range(1)) begin
                h1 = h0;
                h0 = HDR_MARK;
            end
        end else if (kind >= 72 && kind < 78) begin
            do
                cmd = plain_byte();
            while (cmd >= CMD_MIN && cmd <= CMD_MAX);
            cnt = 8'($urandom_range(4));
        end else if (kind >= 78 && kind < 85) begin
            do
                cnt = plain_byte();
            while (count_allowed(cmd, cnt));
        end
        ndata = (cnt > MAX_DATA) ? $urandom_range(MAX_DATA) : int'(cnt);
        do begin
            body = '{h0, h1, cmd, cnt};
            csum = cmd + cnt;
            for (int k = 0; k < ndata; k++) begin
                body.push_back(plain_byte());
                csum = csum + body[$];
            end
        end while (csum == END_MARK);
        sent = csum;
        if (kind >= 85 && kind < 92) begin
            do
                sent = plain_byte();
            while (sent == csum);
        end
        body.push_back(sent);
        // Truncate: drop the tail before the terminator pair
        if (kind >= 92) begin
            cut = $urandom_range(body.size() - 1);
            while (body.size() > cut)
                void'(body.pop_back());
        end
        foreach (body[k])
            queue_byte(body[k]);
        queue_byte(END_MARK);
        queue_byte(END_MARK);
    endtask

    // Frame long enough to saturate the position counter
    task automatic queue_long_frame();
        resync();
        queue_byte(HDR_MARK);
        queue_byte(HDR_MARK);
        queue_byte(8'($urandom_range(CMD_MAX, CMD_MIN)));
        queue_byte(plain_byte());
        repeat (POSITION_LIMIT_DEF + 10)
            queue_byte(plain_byte());
        queue_byte(END_MARK);
        queue_byte(END_MARK);
    endtask

    // Offer requests from the pending queue and predict on each accepted one
    always @(posedge i_clk) begin : driver
        pending_byte_t next_item;
        logic          offer;
        logic          start_hold;
        offer      = i_valid;
        start_hold = 1'b0;
        if (!i_rst_n) begin
            offer = 1'b0;
            wipe_frame();
        end else begin
            if (i_valid && o_ready) begin
                track_rx_byte(i_rx_byte);
                bytes_taken++;
                offer = 1'b0;
            end
            if (!offer && pending.size() != 0) begin
                next_item = pending[0];
                if (!(next_item.pause && frames_due.size() != 0) &&
                    $urandom_range(99) >= sender_idle_pct(next_item.phase)) begin
                    void'(pending.pop_front());
                    offer = 1'b1;
                    i_rx_byte     <= next_item.data;
                    traffic_phase <= next_item.phase;
                    start_hold    = next_item.hold;
                end
            end
        end
        i_valid    <= offer;
        hold_start <= start_hold;
    end

    // Count down the long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n)
            stall_left <= 0;
        else if (hold_start)
            stall_left <= LONG_STALL_CYCLES;
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    // Take results, check them, and throttle ready
    always @(posedge i_clk) begin : monitor
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                check_result();
            i_ready <= (stall_left == 0) &&
                       ($urandom_range(99) >= receiver_idle_pct(traffic_phase));
        end
    end

    initial begin
        int unsigned total_bytes;
        foreach (OPENING[k])
            queue_byte(OPENING[k]);
        for (int ph = 0; ph < 3; ph++) begin
            gen_phase  = traffic_phase_t'(ph);
            pause_next = 1'b1;
            if (gen_phase == PHASE_FULL_RATE) begin
                // Burst of minimal frames while the receiver holds off
                resync();
                hold_next = 1'b1;
                repeat (BURST_FRAMES) begin
                    queue_byte(END_MARK);
                    queue_byte(END_MARK);
                end
                pause_next = 1'b1;
                queue_long_frame();
            end
            while (pending.size() < 450 * (ph + 1))
                queue_frame();
        end
        resync();
        total_bytes = pending.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken != total_bytes)
            @(posedge i_clk);
        while (frames_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout, %0d results still expected", $time, frames_due.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
